@@ rtl/core/structured_grid_face_connectivity_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef STRUCTURED_GRID_FACE_CONNECTIVITY_ASSERT_SVH
`define STRUCTURED_GRID_FACE_CONNECTIVITY_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SGFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error(msg);

// Implication with a fixed delay, disabled while reset is low.
`define SGFC_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##n (cons)) else $error(msg);

`endif

@@ rtl/core/sgfc_pkg.sv @@
package sgfc_pkg;

  localparam int unsigned MaxCellsPerAxis = 1024;

  localparam int unsigned CntW  = 11;  // cell count and face index width
  localparam int unsigned NumW  = 31;  // cell and vertex number width
  localparam int unsigned PipeLatency = 4;

  typedef enum logic [1:0] {
    CFG_CELLS_X = 2'd0,
    CFG_CELLS_Y = 2'd1,
    CFG_CELLS_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    GRP_INTERIOR = 3'd0,
    GRP_X_LOW    = 3'd1,
    GRP_X_HIGH   = 3'd2,
    GRP_Y_LOW    = 3'd3,
    GRP_Y_HIGH   = 3'd4,
    GRP_Z_LOW    = 3'd5,
    GRP_Z_HIGH   = 3'd6
  } group_e;

  typedef struct packed {
    logic [CntW-1:0] cells_x;
    logic [CntW-1:0] cells_y;
    logic [CntW-1:0] cells_z;
  } grid_cfg_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [CntW-1:0] index_x;
    logic [CntW-1:0] index_y;
    logic [CntW-1:0] index_z;
  } face_in_t;

  typedef struct packed {
    logic [NumW-1:0] cell_before;
    logic [NumW-1:0] cell_after;
    group_e          boundary_group;
    logic [NumW-1:0] vertex_a;
    logic [NumW-1:0] vertex_b;
    logic [NumW-1:0] vertex_c;
    logic [NumW-1:0] vertex_d;
    logic            index_error;
  } face_out_t;

endpackage

@@ rtl/core/sgfc_pipe.sv @@
module sgfc_pipe #(
  parameter int unsigned MaxCells = sgfc_pkg::MaxCellsPerAxis
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sgfc_pkg::grid_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  input  sgfc_pkg::face_in_t   face_i,
  output logic                 out_valid_o,
  output sgfc_pkg::face_out_t  result_o
);
  import sgfc_pkg::*;

  localparam int unsigned CxyW = 2 * CntW;
  localparam int unsigned PxW  = CntW + 1;
  localparam int unsigned PxyW = 2 * PxW;

  // Derived grid strides; the user must keep config stable while items are in flight, the block does not enforce it.
  logic [CxyW-1:0] cxy_q;
  logic [PxW-1:0]  px, py;
  logic [PxyW-1:0] pxy_q;

  assign px = PxW'(cfg_i.cells_x) + PxW'(1);
  assign py = PxW'(cfg_i.cells_y) + PxW'(1);

  always_ff @(posedge clk_i) begin
    cxy_q <= CxyW'(cfg_i.cells_x) * CxyW'(cfg_i.cells_y);
    pxy_q <= PxyW'(px) * PxyW'(py);
  end

  // Stage 1: range check and boundary group.
  logic            cnt_ok, in_ok;
  group_e          grp;
  logic            s1_valid_q, s1_ok_q;
  axis_e           s1_axis_q;
  group_e          s1_grp_q;
  logic [CntW-1:0] s1_i_q, s1_j_q, s1_k_q;

  assign cnt_ok = (cfg_i.cells_x != '0) && (32'(cfg_i.cells_x) <= MaxCells) &&
                  (cfg_i.cells_y != '0) && (32'(cfg_i.cells_y) <= MaxCells) &&
                  (cfg_i.cells_z != '0) && (32'(cfg_i.cells_z) <= MaxCells);

  always_comb begin
    in_ok = 1'b0;
    grp   = GRP_INTERIOR;
    case (axis_e'(face_i.action))
      AXIS_X: begin
        in_ok = face_i.index_x <= cfg_i.cells_x && face_i.index_y < cfg_i.cells_y &&
                face_i.index_z < cfg_i.cells_z;
        if (face_i.index_x == '0) grp = GRP_X_LOW;
        else if (face_i.index_x == cfg_i.cells_x) grp = GRP_X_HIGH;
      end
      AXIS_Y: begin
        in_ok = face_i.index_x < cfg_i.cells_x && face_i.index_y <= cfg_i.cells_y &&
                face_i.index_z < cfg_i.cells_z;
        if (face_i.index_y == '0) grp = GRP_Y_LOW;
        else if (face_i.index_y == cfg_i.cells_y) grp = GRP_Y_HIGH;
      end
      AXIS_Z: begin
        in_ok = face_i.index_x < cfg_i.cells_x && face_i.index_y < cfg_i.cells_y &&
                face_i.index_z <= cfg_i.cells_z;
        if (face_i.index_z == '0) grp = GRP_Z_LOW;
        else if (face_i.index_z == cfg_i.cells_z) grp = GRP_Z_HIGH;
      end
      default: begin
        in_ok = 1'b0;
        grp   = GRP_INTERIOR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q   <= cnt_ok && in_ok;
    s1_axis_q <= axis_e'(face_i.action);
    s1_grp_q  <= grp;
    s1_i_q    <= face_i.index_x;
    s1_j_q    <= face_i.index_y;
    s1_k_q    <= face_i.index_z;
  end

  // Stage 2: row and plane products.
  logic              s2_valid_q, s2_ok_q;
  axis_e             s2_axis_q;
  group_e            s2_grp_q;
  logic [CntW-1:0]   s2_i_q;
  logic [NumW-1:0]   s2_jcx_q, s2_kcxy_q, s2_jpx_q, s2_kpxy_q;
  logic [CntW+CxyW-1:0] kcxy_full;
  logic [CntW+PxyW-1:0] kpxy_full;

  assign kcxy_full = (CntW+CxyW)'(s1_k_q) * (CntW+CxyW)'(cxy_q);
  assign kpxy_full = (CntW+PxyW)'(s1_k_q) * (CntW+PxyW)'(pxy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ok_q   <= s1_ok_q;
    s2_axis_q <= s1_axis_q;
    s2_grp_q  <= s1_grp_q;
    s2_i_q    <= s1_i_q;
    s2_jcx_q  <= NumW'(CxyW'(s1_j_q) * CxyW'(cfg_i.cells_x));
    s2_kcxy_q <= kcxy_full[NumW-1:0];
    s2_jpx_q  <= NumW'(PxyW'(s1_j_q) * PxyW'(px));
    s2_kpxy_q <= kpxy_full[NumW-1:0];
  end

  // Stage 3: base cell and base vertex of the face.
  logic            s3_valid_q, s3_ok_q;
  axis_e           s3_axis_q;
  group_e          s3_grp_q;
  logic [NumW-1:0] s3_c0_q, s3_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ok_q   <= s2_ok_q;
    s3_axis_q <= s2_axis_q;
    s3_grp_q  <= s2_grp_q;
    s3_c0_q   <= NumW'(1) + NumW'(s2_i_q) + s2_jcx_q + s2_kcxy_q;
    s3_v0_q   <= NumW'(1) + NumW'(s2_i_q) + s2_jpx_q + s2_kpxy_q;
  end

  // Stage 4: neighbor cells, corner winding, zero on error.
  logic [NumW-1:0] stride, off_a, off_b, off_c;
  logic            low_wall, high_wall;
  face_out_t       res;
  face_out_t       res_q;
  logic            done_q;

  assign low_wall  = s3_grp_q == GRP_X_LOW  || s3_grp_q == GRP_Y_LOW  ||
                     s3_grp_q == GRP_Z_LOW;
  assign high_wall = s3_grp_q == GRP_X_HIGH || s3_grp_q == GRP_Y_HIGH ||
                     s3_grp_q == GRP_Z_HIGH;

  always_comb begin
    case (s3_axis_q)
      AXIS_X: begin
        stride = NumW'(1);
        off_a  = NumW'(px);
        off_b  = NumW'(px) + NumW'(pxy_q);
        off_c  = NumW'(pxy_q);
      end
      AXIS_Y: begin
        stride = NumW'(cfg_i.cells_x);
        off_a  = NumW'(pxy_q);
        off_b  = NumW'(pxy_q) + NumW'(1);
        off_c  = NumW'(1);
      end
      default: begin
        stride = NumW'(cxy_q);
        off_a  = NumW'(1);
        off_b  = NumW'(px) + NumW'(1);
        off_c  = NumW'(px);
      end
    endcase

    res = '0;
    res.index_error = !s3_ok_q;
    if (s3_ok_q) begin
      res.cell_before    = low_wall  ? '0 : s3_c0_q - stride;
      res.cell_after     = high_wall ? '0 : s3_c0_q;
      res.boundary_group = s3_grp_q;
      res.vertex_a       = s3_v0_q + off_a;
      res.vertex_b       = s3_v0_q + off_b;
      res.vertex_c       = s3_v0_q + off_c;
      res.vertex_d       = s3_v0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res;
  end

  assign out_valid_o = done_q;
  assign result_o    = res_q;

endmodule

@@ rtl/core/structured_grid_face_connectivity.sv @@
// Channel   | Direction | Handshake                 | Beat
// ----------+-----------+---------------------------+------------------------------------
// face      | in        | start_i high, busy_o low  | face_i: action, index_x/y/z
// result    | out       | done_o strobe, one cycle  | result_o: cells, group, vertices, error
// config    | in        | cfg_valid_i & cfg_ready_o | cfg_index_i, cfg_data_i (cell counts)
//
// One face beat enters every cycle while busy_o is low; its result strobes on done_o
// after passing the four register stages (check, multiply, add, finish).
// Async active-low reset clears the stage valid bits and sets cell counts to 1;
// busy_o stays high and cfg_ready_o low until the first clock edge after reset release.
// The receiver cannot stall, so the pipeline never holds: each stage advances every cycle.
module structured_grid_face_connectivity #(
  parameter int unsigned MaxCells = sgfc_pkg::MaxCellsPerAxis
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // face channel
  input  logic                start_i,
  output logic                busy_o,
  input  sgfc_pkg::face_in_t  face_i,
  // result channel
  output logic                done_o,
  output sgfc_pkg::face_out_t result_o,
  // configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i
);
  import sgfc_pkg::*;

  // Run flag: low in reset, high from the first cycle after release.
  logic run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= 1'b1;
    end
  end

  assign busy_o      = !run_q;
  assign cfg_ready_o = run_q;

  // Cell count registers; a write to an index past the list is dropped.
  grid_cfg_t cfg_q;
  logic      cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cells_x <= CntW'(1);
      cfg_q.cells_y <= CntW'(1);
      cfg_q.cells_z <= CntW'(1);
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CELLS_X: begin
          cfg_q.cells_x <= cfg_data_i;
        end
        CFG_CELLS_Y: begin
          cfg_q.cells_y <= cfg_data_i;
        end
        CFG_CELLS_Z: begin
          cfg_q.cells_z <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Accept a face beat whenever not busy; the pipe never pushes back.
  logic in_accept;

  assign in_accept = start_i && !busy_o;

  sgfc_pipe #(
    .MaxCells (MaxCells)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_accept),
    .face_i      (face_i),
    .out_valid_o (done_o),
    .result_o    (result_o)
  );

endmodule

@@ rtl/core/sgfc_checker.sv @@
`include "structured_grid_face_connectivity_assert.svh"

module sgfc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input sgfc_pkg::face_out_t result_o
);
  import sgfc_pkg::*;

  logic face_acc;
  logic err_strobe;
  logic ok_strobe;
  logic fields_zero;
  logic interior;
  logic both_cells;

  assign face_acc    = start_i && !busy_o;
  assign err_strobe  = done_o && result_o.index_error;
  assign ok_strobe   = done_o && !result_o.index_error;
  assign fields_zero = result_o.cell_before == '0 && result_o.cell_after == '0 &&
                       result_o.boundary_group == GRP_INTERIOR &&
                       result_o.vertex_a == '0 && result_o.vertex_d == '0;
  assign interior    = result_o.boundary_group == GRP_INTERIOR;
  assign both_cells  = result_o.cell_before != '0 && result_o.cell_after != '0;

  `SGFC_ASSERT_DELAY(a_accept_gives_result, clk_i, rst_ni, face_acc, 4, done_o, "beat lost")
  `SGFC_ASSERT_IMPLY(a_result_has_cause, clk_i, rst_ni, done_o, $past(face_acc, 4), "no cause")
  `SGFC_ASSERT_IMPLY(a_error_zero_fields, clk_i, rst_ni, err_strobe, fields_zero, "error fields")
  `SGFC_ASSERT_IMPLY(a_wall_one_sided, clk_i, rst_ni, ok_strobe, interior == both_cells, "walls")

endmodule

bind structured_grid_face_connectivity sgfc_checker u_sgfc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

@@ tb/tb_structured_grid_face_connectivity.sv @@
`timescale 1ns / 1ps

module tb_structured_grid_face_connectivity;
  import sgfc_pkg::*;

  // Hard stop on a hung run.
  localparam int unsigned CyclesMax    = 200000;
  // Extra cycles after the last result, so that a stray late strobe is still seen.
  localparam int unsigned SettleCycles = PipeLatency + 2;
  // Codes that the package leaves without a name.
  localparam logic [1:0] AxisUnused = 2'd3;
  localparam logic [1:0] CfgUnused  = 2'd3;
  localparam int unsigned IndexMax  = (1 << CntW) - 1;
  localparam int unsigned ReportMax = 30;

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  face_in_t        face_i;
  logic            done_o;
  face_out_t       result_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i;
  logic [CntW-1:0] cfg_data_i;

  // Grid shape as the block should hold it, updated on each register beat.
  logic [CntW-1:0] grid_x;
  logic [CntW-1:0] grid_y;
  logic [CntW-1:0] grid_z;

  face_out_t   pending_faces[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned idle_pct;

  structured_grid_face_connectivity uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .face_i     (face_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Face connectivity predictor
  // ---------------------------------------------------------------------------

  function automatic bit count_ok(longint unsigned n);
    return n >= 1 && n <= MaxCellsPerAxis;
  endfunction

  // 1-based cell number, x fastest, then y, then z.
  function automatic longint unsigned cell_num(longint unsigned a, longint unsigned b,
                                               longint unsigned c);
    longint unsigned nx, ny;
    nx = grid_x;
    ny = grid_y;
    return 1 + a + b * nx + c * nx * ny;
  endfunction

  // 1-based vertex number on the (nx+1) x (ny+1) x (nz+1) lattice.
  function automatic longint unsigned vert_num(longint unsigned a, longint unsigned b,
                                               longint unsigned c);
    longint unsigned px, py;
    px = longint'(grid_x) + 1;
    py = longint'(grid_y) + 1;
    return 1 + a + b * px + c * px * py;
  endfunction

  function automatic face_out_t connect_face(face_in_t f);
    longint unsigned nx, ny, nz, i, j, k;
    longint unsigned below, after, va, vb, vc, vd;
    group_e          grp;
    bit              ok;
    face_out_t       r;
    nx = grid_x;
    ny = grid_y;
    nz = grid_z;
    i = f.index_x;
    j = f.index_y;
    k = f.index_z;
    below = 0;
    after = 0;
    va = 0;
    vb = 0;
    vc = 0;
    vd = 0;
    grp = GRP_INTERIOR;
    ok = count_ok(nx) && count_ok(ny) && count_ok(nz);
    // A face exists when its normal index is at most the count and the others stay below it.
    if (ok) begin
      case (f.action)
        AXIS_X:  ok = i <= nx && j < ny && k < nz;
        AXIS_Y:  ok = i < nx && j <= ny && k < nz;
        AXIS_Z:  ok = i < nx && j < ny && k <= nz;
        default: ok = 1'b0;
      endcase
    end
    if (ok) begin
      case (f.action)
        AXIS_X: begin
          if (i == 0) begin
            after = cell_num(i, j, k);
            grp   = GRP_X_LOW;
          end else if (i == nx) begin
            below = cell_num(i - 1, j, k);
            grp   = GRP_X_HIGH;
          end else begin
            below = cell_num(i - 1, j, k);
            after = cell_num(i, j, k);
          end
          va = vert_num(i, j + 1, k);
          vb = vert_num(i, j + 1, k + 1);
          vc = vert_num(i, j, k + 1);
          vd = vert_num(i, j, k);
        end
        AXIS_Y: begin
          if (j == 0) begin
            after = cell_num(i, j, k);
            grp   = GRP_Y_LOW;
          end else if (j == ny) begin
            below = cell_num(i, j - 1, k);
            grp   = GRP_Y_HIGH;
          end else begin
            below = cell_num(i, j - 1, k);
            after = cell_num(i, j, k);
          end
          va = vert_num(i, j, k + 1);
          vb = vert_num(i + 1, j, k + 1);
          vc = vert_num(i + 1, j, k);
          vd = vert_num(i, j, k);
        end
        default: begin
          if (k == 0) begin
            after = cell_num(i, j, k);
            grp   = GRP_Z_LOW;
          end else if (k == nz) begin
            below = cell_num(i, j, k - 1);
            grp   = GRP_Z_HIGH;
          end else begin
            below = cell_num(i, j, k - 1);
            after = cell_num(i, j, k);
          end
          va = vert_num(i + 1, j, k);
          vb = vert_num(i + 1, j + 1, k);
          vc = vert_num(i, j + 1, k);
          vd = vert_num(i, j, k);
        end
      endcase
    end
    r.cell_before    = below[NumW-1:0];
    r.cell_after     = after[NumW-1:0];
    r.boundary_group = grp;
    r.vertex_a       = va[NumW-1:0];
    r.vertex_b       = vb[NumW-1:0];
    r.vertex_c       = vc[NumW-1:0];
    r.vertex_d       = vd[NumW-1:0];
    r.index_error    = !ok;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Count every mismatch; print only the first few to keep the log short.
  task automatic report_mismatch(string what, logic [NumW-1:0] got, logic [NumW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= ReportMax)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(string what, logic [NumW-1:0] got, logic [NumW-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sample every port at the rising edge, before the block updates them.
  // Order within the edge does not matter: a result only returns after its face beat has
  // passed the pipeline registers, and register beats only land while idle.
  always @(posedge clk_i) begin : watch_ports
    face_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_faces.size() == 0) begin
          report_mismatch("result with nothing pending", result_o.cell_before, '0);
        end else begin
          want = pending_faces.pop_front();
          check_field("cell_before", result_o.cell_before, want.cell_before);
          check_field("cell_after", result_o.cell_after, want.cell_after);
          check_field("boundary_group", NumW'(result_o.boundary_group),
                      NumW'(want.boundary_group));
          check_field("vertex_a", result_o.vertex_a, want.vertex_a);
          check_field("vertex_b", result_o.vertex_b, want.vertex_b);
          check_field("vertex_c", result_o.vertex_c, want.vertex_c);
          check_field("vertex_d", result_o.vertex_d, want.vertex_d);
          check_field("index_error", NumW'(result_o.index_error), NumW'(want.index_error));
        end
      end
      if (start_i && !busy_o) pending_faces.push_back(connect_face(face_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CELLS_X: grid_x = cfg_data_i;
          CFG_CELLS_Y: grid_y = cfg_data_i;
          CFG_CELLS_Z: grid_z = cfg_data_i;
          default: ;  // writes past the register list are dropped
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CyclesMax) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one face and hold it until accepted. start_i is left high on
  // return so the next beat can follow back to back; drop it before any
  // other wait. Each cycle in front of the beat stays idle with a chance of
  // idle_pct in a hundred.
  task automatic send_face(face_in_t f);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    face_i  <= f;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_axis(logic [1:0] action, int unsigned i, int unsigned j,
                           int unsigned k);
    face_in_t f;
    f.action  = action;
    f.index_x = i[CntW-1:0];
    f.index_y = j[CntW-1:0];
    f.index_z = k[CntW-1:0];
    send_face(f);
  endtask

  // Drop start, then hold until every pending result has come back and the
  // pipeline has had time to flush.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_faces.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register beat; cfg_valid_i stays high on return, the caller drops it.
  task automatic write_reg(logic [1:0] idx, logic [CntW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_grid(int unsigned nx, int unsigned ny, int unsigned nz);
    drain_results();
    write_reg(CFG_CELLS_X, nx[CntW-1:0]);
    write_reg(CFG_CELLS_Y, ny[CntW-1:0]);
    write_reg(CFG_CELLS_Z, nz[CntW-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly faces that exist, with walls favored on the normal axis; some
  // one past the edge; the rest raw noise over the full field widths.
  function automatic face_in_t make_face(int unsigned nx, int unsigned ny, int unsigned nz);
    int unsigned span[3];
    int unsigned pick[3];
    int unsigned ax, roll, a;
    face_in_t    f;
    span[0] = (nx > 0) ? nx : 1;
    span[1] = (ny > 0) ? ny : 1;
    span[2] = (nz > 0) ? nz : 1;
    roll = $urandom_range(99, 0);
    ax   = $urandom_range(2, 0);
    for (a = 0; a < 3; a++) pick[a] = $urandom_range(span[a] - 1, 0);
    case ($urandom_range(3, 0))
      0:       pick[ax] = 0;
      1:       pick[ax] = span[ax];
      default: pick[ax] = $urandom_range(span[ax], 0);
    endcase
    if (roll >= 85 && roll < 93) begin
      a = $urandom_range(2, 0);
      pick[a] = (a == ax) ? span[a] + 1 : span[a];
    end
    f.action  = ax[1:0];
    f.index_x = pick[0][CntW-1:0];
    f.index_y = pick[1][CntW-1:0];
    f.index_z = pick[2][CntW-1:0];
    if (roll >= 93) begin
      f.action  = 2'($urandom_range(3, 0));
      f.index_x = CntW'($urandom_range(IndexMax, 0));
      f.index_y = CntW'($urandom_range(IndexMax, 0));
      f.index_z = CntW'($urandom_range(IndexMax, 0));
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset shape is one cell: both x walls, a y and a z wall, one face past the edge.
  task automatic test_reset_grid();
    idle_pct = 0;
    send_axis(AXIS_X, 0, 0, 0);
    send_axis(AXIS_X, 1, 0, 0);
    send_axis(AXIS_Y, 0, 0, 0);
    send_axis(AXIS_Z, 0, 0, 1);
    send_axis(AXIS_X, 2, 0, 0);
  endtask

  // Every wall group, interior faces on each axis, out-of-range tangential
  // and normal indices, and the unused axis code.
  task automatic test_boundaries();
    set_grid(3, 4, 5);
    send_axis(AXIS_X, 0, 3, 4);
    send_axis(AXIS_X, 3, 1, 2);
    send_axis(AXIS_X, 1, 2, 3);
    send_axis(AXIS_Y, 2, 0, 4);
    send_axis(AXIS_Y, 0, 4, 1);
    send_axis(AXIS_Y, 1, 2, 0);
    send_axis(AXIS_Z, 2, 3, 0);
    send_axis(AXIS_Z, 0, 0, 5);
    send_axis(AXIS_Z, 1, 1, 2);
    send_axis(AXIS_X, 1, 4, 0);
    send_axis(AXIS_Z, 0, 0, 6);
    send_axis(AxisUnused, 0, 0, 0);
  endtask

  // Largest grid: top corner faces reach the widest cell and vertex numbers.
  task automatic test_extreme_grid();
    set_grid(MaxCellsPerAxis, MaxCellsPerAxis, MaxCellsPerAxis);
    send_axis(AXIS_X, 1024, 1023, 1023);
    send_axis(AXIS_Y, 1023, 1024, 1023);
    send_axis(AXIS_Z, 1023, 1023, 1024);
    send_axis(AXIS_X, IndexMax, IndexMax, IndexMax);
  endtask

  // Zero and oversize counts turn every face into an error; a write past the
  // register list must leave the shape alone.
  task automatic test_bad_counts();
    set_grid(0, 4, 4);
    send_axis(AXIS_Z, 0, 0, 0);
    set_grid(1025, 1, 1);
    send_axis(AXIS_X, 0, 0, 0);
    set_grid(IndexMax, IndexMax, IndexMax);
    send_axis(AXIS_X, 0, 0, 0);
    set_grid(2, 2, 2);
    drain_results();
    write_reg(CfgUnused, 11'd0);
    cfg_valid_i <= 1'b0;
    send_axis(AXIS_X, 2, 1, 1);
  endtask

  task automatic test_random_faces(int unsigned count, int unsigned pct, int unsigned nx,
                                   int unsigned ny, int unsigned nz);
    set_grid(nx, ny, nz);
    idle_pct = pct;
    repeat (count) send_face(make_face(nx, ny, nz));
  endtask

  // Stop sending until the pipeline is empty, then resume on the same grid.
  task automatic test_drain_pause(int unsigned nx, int unsigned ny, int unsigned nz);
    set_grid(nx, ny, nz);
    idle_pct = 13;
    repeat (100) send_face(make_face(nx, ny, nz));
    drain_results();
    repeat (100) send_face(make_face(nx, ny, nz));
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    face_i         <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    grid_x          = 1;
    grid_y          = 1;
    grid_z          = 1;
    mismatch_count  = 0;
    cycle_count     = 0;
    idle_pct        = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_grid();
    test_boundaries();
    test_extreme_grid();
    test_bad_counts();

    test_random_faces(250, 0, $urandom_range(8, 1), $urandom_range(8, 1),
                      $urandom_range(8, 1));
    test_random_faces(200, 76, MaxCellsPerAxis, MaxCellsPerAxis, MaxCellsPerAxis);
    test_random_faces(250, 13, $urandom_range(64, 1), $urandom_range(64, 1),
                      $urandom_range(64, 1));
    test_random_faces(150, 0, 1, MaxCellsPerAxis, 1);
    test_random_faces(200, 76, $urandom_range(MaxCellsPerAxis, 1),
                      $urandom_range(MaxCellsPerAxis, 1), $urandom_range(MaxCellsPerAxis, 1));
    test_random_faces(100, 13, 1, 1, 1);
    test_random_faces(50, 0, $urandom_range(1, 0) ? 0 : $urandom_range(IndexMax, 1025),
                      $urandom_range(16, 1), $urandom_range(16, 1));
    test_drain_pause($urandom_range(16, 1), $urandom_range(16, 1), $urandom_range(16, 1));

    drain_results();
    if (pending_faces.size() != 0)
      report_mismatch("results never returned", NumW'(pending_faces.size()), '0);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
